[hdl/frwm_pkg.sv]
// Shared types and constants of the frame rate window meter.
`default_nettype none
package frwm_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned DUR_W  = 16;
    localparam int unsigned FPS_W  = 24;
    localparam int unsigned FRAC_W = 8;
    localparam int unsigned ODATA_W = 88;

    localparam logic [9:0]       MS_PER_S = 10'd1000;
    localparam logic [FPS_W-1:0] FPS_MAX  = {FPS_W{1'b1}};
    localparam logic [DUR_W-1:0] DUR_MAX  = {DUR_W{1'b1}};

    typedef enum logic
    {
        FUNC_START = 1'b0,
        FUNC_FRAME = 1'b1
    } func_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } frwm_div_stat_t;

endpackage
`default_nettype wire

[hdl/frwm_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module frwm_div #(
    parameter int unsigned NUM_W = 22,
    parameter int unsigned DEN_W = 20
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [NUM_W-1:0]      num,
    input  wire logic [DEN_W-1:0]      den,
    output logic [NUM_W-1:0]           quot,
    output frwm_pkg::frwm_div_stat_t   stat
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_sr_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             borrow;

    assign trial  = {rem_reg, num_sr_reg[NUM_W-1]} - {1'b0, den_reg};
    assign borrow = trial[DEN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sr_reg <= '0;
            den_reg    <= '0;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else if (start)
        begin
            num_sr_reg <= num;
            den_reg    <= den;
            rem_reg    <= '0;
            cnt_reg    <= CNT_W'(NUM_W);
            busy_reg   <= 1'b1;
            done_reg   <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_sr_reg <= {num_sr_reg[NUM_W-2:0], ~borrow};
            rem_reg    <= borrow ? {rem_reg[DEN_W-2:0], num_sr_reg[NUM_W-1]}
                                 : trial[DEN_W-1:0];
            cnt_reg    <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quot      = num_sr_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a finished run");

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with empty step count");

endmodule
`default_nettype wire

[hdl/frame_rate_window_meter_unit.sv]
// Top level of the moving-average frame rate meter.
// A start word (tuser 0) only records its timestamp. A frame word (tuser 1) passes through
// these steps before its result sits in a free output register: the bit-serial subtractors that
// form the frame delta and the duration, an update of the ring of WINDOW durations and its
// running sum, the bit-serial divider, its load included (NUM_W = clog2(1000*WINDOW+1) + 8,
// 22 at WINDOW 16), and the hand-over of the word. A result still waiting in the output
// register holds the frame word in its hand-over step. The input is ready again once the
// result is in the output register. A zero window sum skips the divider and flags the rate
// invalid.
`default_nettype none
module frame_rate_window_meter_unit #(
    parameter int unsigned WINDOW = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] time_ms
    input  wire logic        s_tuser,   // [0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [31:0] frames_seen, [63:32] delta_ms, [87:64] fps_q8
    output logic             m_tuser    // [0] fps_invalid
);

    localparam int unsigned TIME_W = frwm_pkg::TIME_W;
    localparam int unsigned DUR_W  = frwm_pkg::DUR_W;
    localparam int unsigned FPS_W  = frwm_pkg::FPS_W;
    localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned WIN_W  = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W  = DUR_W + $clog2(WINDOW);
    localparam int unsigned RATE_W = $clog2(1000 * WINDOW + 1);
    localparam int unsigned NUM_W  = RATE_W + frwm_pkg::FRAC_W;
    localparam int unsigned QX_W   = (NUM_W > FPS_W) ? NUM_W : FPS_W;
    localparam int unsigned BIT_W  = $clog2(TIME_W);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SUB,
        ST_UPD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [TIME_W-1:0]     ref_reg;
    logic [TIME_W-1:0]     prev_reg;
    logic [TIME_W-1:0]     delta_reg;
    logic [TIME_W-1:0]     dur_reg;
    logic                  bd_reg;
    logic                  br_reg;
    logic [TIME_W-1:0]     frames_reg;
    logic [WIN_W-1:0]      win_reg;
    logic [PTR_W-1:0]      ptr_reg;
    logic [WINDOW-1:0]     valid_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [DUR_W-1:0]      rd_reg;
    logic                  old_valid_reg;
    logic                  inv_reg;
    logic                  m_tvalid_reg;
    logic [87:0]           m_tdata_reg;
    logic                  m_tuser_reg;

    logic [DUR_W-1:0]      ring [WINDOW];

    logic                  in_acc;
    logic                  frame_acc;
    logic                  d_bit;
    logic                  r_bit;
    logic                  bd_next;
    logic                  br_next;
    logic [DUR_W-1:0]      dur_sat;
    logic [DUR_W-1:0]      old_dur;
    logic [SUM_W-1:0]      sum_next;
    logic [RATE_W-1:0]     rate_num;
    logic                  div_start;
    logic [NUM_W-1:0]      quot;
    logic [QX_W-1:0]       quot_x;
    logic [FPS_W-1:0]      fps;
    logic                  out_free;
    frwm_pkg::frwm_div_stat_t div_stat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign frame_acc = in_acc && (s_tuser == frwm_pkg::FUNC_FRAME);

    assign d_bit   = now_reg[0] ^ prev_reg[0] ^ bd_reg;
    assign bd_next = (~now_reg[0] & prev_reg[0]) | (~(now_reg[0] ^ prev_reg[0]) & bd_reg);
    assign r_bit   = now_reg[0] ^ ref_reg[0] ^ br_reg;
    assign br_next = (~now_reg[0] & ref_reg[0]) | (~(now_reg[0] ^ ref_reg[0]) & br_reg);

    assign dur_sat  = (|dur_reg[TIME_W-1:DUR_W]) ? frwm_pkg::DUR_MAX : dur_reg[DUR_W-1:0];
    assign old_dur  = old_valid_reg ? rd_reg : '0;
    assign sum_next = sum_reg - SUM_W'(old_dur) + SUM_W'(dur_sat);
    assign rate_num = RATE_W'(RATE_W'(win_reg) * RATE_W'(frwm_pkg::MS_PER_S));

    assign div_start = (state_reg == ST_UPD) && (sum_next != '0);
    assign quot_x    = QX_W'(quot);
    assign fps       = inv_reg ? '0
                     : ((quot_x > QX_W'(frwm_pkg::FPS_MAX)) ? frwm_pkg::FPS_MAX
                                                            : quot_x[FPS_W-1:0]);
    assign out_free  = !m_tvalid_reg || m_tready;

    frwm_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({rate_num, {frwm_pkg::FRAC_W{1'b0}}}),
        .den   (sum_next),
        .quot  (quot),
        .stat  (div_stat)
    );

    always_ff @(posedge clk)
    begin
        if (frame_acc)
        begin
            rd_reg <= ring[ptr_reg];
        end
        if (state_reg == ST_UPD)
        begin
            ring[ptr_reg] <= dur_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_reg       <= '0;
            now_reg       <= '0;
            ref_reg       <= '0;
            prev_reg      <= '0;
            delta_reg     <= '0;
            dur_reg       <= '0;
            bd_reg        <= 1'b0;
            br_reg        <= 1'b0;
            frames_reg    <= '0;
            win_reg       <= '0;
            ptr_reg       <= '0;
            valid_reg     <= '0;
            sum_reg       <= '0;
            old_valid_reg <= 1'b0;
            inv_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && !frame_acc)
                    begin
                        ref_reg <= s_tdata;
                    end
                    else if (frame_acc)
                    begin
                        now_reg       <= s_tdata;
                        bd_reg        <= 1'b0;
                        br_reg        <= 1'b0;
                        bit_reg       <= '0;
                        old_valid_reg <= valid_reg[ptr_reg];
                        if (frames_reg != '1)
                        begin
                            frames_reg <= frames_reg + TIME_W'(1);
                        end
                        if (win_reg != WIN_W'(WINDOW))
                        begin
                            win_reg <= win_reg + WIN_W'(1);
                        end
                        state_reg <= ST_SUB;
                    end
                end
                ST_SUB:
                begin
                    now_reg   <= {now_reg[0], now_reg[TIME_W-1:1]};
                    prev_reg  <= {1'b0, prev_reg[TIME_W-1:1]};
                    ref_reg   <= {1'b0, ref_reg[TIME_W-1:1]};
                    delta_reg <= {d_bit, delta_reg[TIME_W-1:1]};
                    dur_reg   <= {r_bit, dur_reg[TIME_W-1:1]};
                    bd_reg    <= bd_next;
                    br_reg    <= br_next;
                    bit_reg   <= bit_reg + BIT_W'(1);
                    if (bit_reg == BIT_W'(TIME_W - 1))
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    ref_reg            <= now_reg;
                    prev_reg           <= now_reg;
                    sum_reg            <= sum_next;
                    valid_reg[ptr_reg] <= 1'b1;
                    ptr_reg            <= (ptr_reg == PTR_W'(WINDOW - 1)) ? '0
                                                                        : ptr_reg + PTR_W'(1);
                    inv_reg            <= (sum_next == '0);
                    state_reg          <= (sum_next == '0) ? ST_DONE : ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg  <= {fps, delta_reg, frames_reg};
                        m_tuser_reg  <= inv_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
        win_reg <= WIN_W'(WINDOW))
        else $error("window count above window depth");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(sum_reg) <= SUM_W'(WINDOW * 65535))
        else $error("window sum above its ceiling");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the hand-over phase");

endmodule
`default_nettype wire
